[rtl/lr_pkg.sv]
// Shared types and constants for the line rasterizer.
// No dependencies; imported by the controller, datapath and top level.
package lr_pkg;

  localparam int PIX_W     = 6;
  localparam int COL_W     = 8;
  localparam int FRAME_W   = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FRAME_W-1:0] FRAME_RESET = 7'd64;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture a new segment request
    logic emit;   // move current pixel to output register and advance
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic at_end; // current pixel is the segment's end point
  } sts_t;

endpackage

[rtl/lr_ctrl.sv]
// Controller of the line rasterizer: segment state machine and output valid.
// Depends on lr_pkg.
module lr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output lr_pkg::cmd_t  cmd,
  input  lr_pkg::sts_t  sts
);
  import lr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (slot_free && sts.at_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.emit = slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // hold a stalled pixel, drop it once taken unless a new one is emitted
  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else          out_valid_nxt = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/lr_dp.sv]
// Datapath of the line rasterizer: segment setup, Bresenham stepping,
// frame registers and the output pixel register. Depends on lr_pkg.
module lr_dp #(
  parameter int COORD_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lr_pkg::cmd_t                 cmd,
  output lr_pkg::sts_t                 sts,
  input  logic                         cfg_wr_en,
  input  logic [lr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lr_pkg::FRAME_W-1:0]   cfg_data,
  input  logic [lr_pkg::PIX_W-1:0]     in_x_start,
  input  logic [lr_pkg::PIX_W-1:0]     in_y_start,
  input  logic [lr_pkg::PIX_W-1:0]     in_x_end,
  input  logic [lr_pkg::PIX_W-1:0]     in_y_end,
  input  logic [lr_pkg::COL_W-1:0]     in_red,
  input  logic [lr_pkg::COL_W-1:0]     in_green,
  input  logic [lr_pkg::COL_W-1:0]     in_blue,
  output logic [lr_pkg::PIX_W-1:0]     out_pixel_x,
  output logic [lr_pkg::PIX_W-1:0]     out_pixel_y,
  output logic [lr_pkg::COL_W-1:0]     out_red_out,
  output logic [lr_pkg::COL_W-1:0]     out_green_out,
  output logic [lr_pkg::COL_W-1:0]     out_blue_out,
  output logic                         out_inside_res,
  output logic                         out_last
);
  import lr_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 3;  // signed error word

  // frame registers
  logic [FRAME_W-1:0] frame_w_r, frame_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= FRAME_RESET;
      frame_h_r <= FRAME_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_w_r <= cfg_data;
        CFG_FRAME_HEIGHT: frame_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // segment setup from the incoming request
  logic [CW-1:0]        x0, y0, x1, y1, dx, dy, major, minor;
  logic                 x_dn, y_dn, x_major;
  logic signed [EW-1:0] maj_e, min_e, ai_set, bi_set, d_set;

  assign x0 = in_x_start[CW-1:0];
  assign y0 = in_y_start[CW-1:0];
  assign x1 = in_x_end[CW-1:0];
  assign y1 = in_y_end[CW-1:0];

  assign x_dn    = !(x0 < x1);
  assign y_dn    = !(y0 < y1);
  assign dx      = x_dn ? (x0 - x1) : (x1 - x0);
  assign dy      = y_dn ? (y0 - y1) : (y1 - y0);
  assign x_major = dx > dy;
  assign major   = x_major ? dx : dy;
  assign minor   = x_major ? dy : dx;
  assign maj_e   = signed'(EW'(major));
  assign min_e   = signed'(EW'(minor));
  assign ai_set  = (min_e - maj_e) <<< 1;
  assign bi_set  = min_e <<< 1;
  assign d_set   = bi_set - maj_e;

  // walker state
  logic [CW-1:0]        cur_x_r, cur_y_r, end_x_r, end_y_r;
  logic                 x_dn_r, y_dn_r, x_major_r;
  logic signed [EW-1:0] ai_r, bi_r, d_r;
  logic [COL_W-1:0]     red_r, green_r, blue_r;

  logic [CW-1:0]        x_step, y_step, cur_x_nxt, cur_y_nxt;
  logic signed [EW-1:0] d_nxt;
  logic                 at_end;

  assign at_end = x_major_r ? (cur_x_r == end_x_r) : (cur_y_r == end_y_r);
  assign sts.at_end = at_end;

  assign x_step = x_dn_r ? (cur_x_r - CW'(1)) : (cur_x_r + CW'(1));
  assign y_step = y_dn_r ? (cur_y_r - CW'(1)) : (cur_y_r + CW'(1));

  always_comb begin
    if (!d_r[EW-1]) begin
      // diagonal step
      cur_x_nxt = x_step;
      cur_y_nxt = y_step;
      d_nxt     = d_r + ai_r;
    end else begin
      cur_x_nxt = x_major_r ? x_step : cur_x_r;
      cur_y_nxt = x_major_r ? cur_y_r : y_step;
      d_nxt     = d_r + bi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r   <= x0;
      cur_y_r   <= y0;
      end_x_r   <= x1;
      end_y_r   <= y1;
      x_dn_r    <= x_dn;
      y_dn_r    <= y_dn;
      x_major_r <= x_major;
      ai_r      <= ai_set;
      bi_r      <= bi_set;
      d_r       <= d_set;
      red_r     <= in_red;
      green_r   <= in_green;
      blue_r    <= in_blue;
    end else if (cmd.emit) begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      d_r     <= d_nxt;
    end
  end

  // output pixel register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pixel_x    <= PIX_W'(cur_x_r);
      out_pixel_y    <= PIX_W'(cur_y_r);
      out_red_out    <= red_r;
      out_green_out  <= green_r;
      out_blue_out   <= blue_r;
      out_inside_res <= (FRAME_W'(cur_x_r) < frame_w_r) && (FRAME_W'(cur_y_r) < frame_h_r);
      out_last       <= at_end;
    end
  end

endmodule

[rtl/line_rasterizer_core.sv]
// Line rasterizer top level: joins lr_ctrl and lr_dp.
// Depends on lr_pkg, lr_ctrl, lr_dp.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   x_start, y_start, x_end, y_end, rgb
//   out      output     out_valid / out_stall pixel_x, pixel_y, rgb, inside_res, last
//   cfg      input      cfg_wr_en             cfg_index, cfg_data
//
// A segment is taken, then emits max(dx, dy) + 1 pixels at one pixel per
// cycle from the Bresenham stepper while the output is not stalled. The next
// segment is taken while the final pixel still waits in the output register.
// Reset is synchronous, active low; frame registers reset to 64.
// Output stall freezes the stepper; the input is stalled while a segment runs.
module line_rasterizer_core #(
  parameter int COORD_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [lr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lr_pkg::FRAME_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lr_pkg::PIX_W-1:0]     in_x_start,
  input  logic [lr_pkg::PIX_W-1:0]     in_y_start,
  input  logic [lr_pkg::PIX_W-1:0]     in_x_end,
  input  logic [lr_pkg::PIX_W-1:0]     in_y_end,
  input  logic [lr_pkg::COL_W-1:0]     in_red,
  input  logic [lr_pkg::COL_W-1:0]     in_green,
  input  logic [lr_pkg::COL_W-1:0]     in_blue,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lr_pkg::PIX_W-1:0]     out_pixel_x,
  output logic [lr_pkg::PIX_W-1:0]     out_pixel_y,
  output logic [lr_pkg::COL_W-1:0]     out_red_out,
  output logic [lr_pkg::COL_W-1:0]     out_green_out,
  output logic [lr_pkg::COL_W-1:0]     out_blue_out,
  output logic                         out_inside_res,
  output logic                         out_last
);
  import lr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lr_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_inside_res (out_inside_res),
    .out_last       (out_last)
  );

  // an accepted request keeps the input stalled while its pixels are walked
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after segment accepted");

  // the input reopens only once the final pixel sits in the output register
  a_reopen_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_stall) |-> out_valid && out_last)
    else $error("input reopened before final pixel");

  // a taken pixel that is not the last is followed at once by the next one
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside a segment");

endmodule
